>>> rtl/core/rmq_pkg.sv
// Package for the rotation matrix to quaternion block.
// Holds shared constants, the side-band struct and the leading-one search.
// No dependencies.
package rmq_pkg;

    localparam logic [31:0] RMQ_ONE_Q30   = 32'h4000_0000;
    localparam int          RMQ_FRONT_LAT = 9;
    localparam int          RMQ_SQRT_LAT  = 32;
    localparam int          RMQ_DIV_LAT   = 32;
    localparam int          RMQ_LAT       = RMQ_FRONT_LAT + RMQ_SQRT_LAT + RMQ_DIV_LAT + 1;
    // Below this magnitude a component can belong to a vector short enough to fall back.
    localparam logic [33:0] RMQ_SMALL_LIM = 34'd4295;
    localparam logic [19:0] RMQ_SHORT_K   = 20'd1000000;

    typedef struct packed {
        logic [3:0][30:0] mag;
        logic [3:0]       neg;
        logic             fb;
    } t_side;

    function automatic logic [5:0] msb_pos(input logic [33:0] x);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 34; i++) begin
            if (x[i]) begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

endpackage

>>> rtl/core/rmq_front.sv
// Front pipeline: branch selection, magnitudes, short-length test,
// normalization and sum of squares. Nine register stages.
// Depends on rmq_pkg.
module rmq_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [31:0]   i_r00,
    input  logic signed [31:0]   i_r01,
    input  logic signed [31:0]   i_r02,
    input  logic signed [31:0]   i_r10,
    input  logic signed [31:0]   i_r11,
    input  logic signed [31:0]   i_r12,
    input  logic signed [31:0]   i_r20,
    input  logic signed [31:0]   i_r21,
    input  logic signed [31:0]   i_r22,
    output logic                 o_valid,
    output logic [63:0]          o_sum,
    output rmq_pkg::t_side       o_side
);

    localparam logic signed [34:0] ONE35 = 35'sd1073741824;

    logic [8:0] r_vld;

    // Stage 1
    logic signed [33:0] r1_tr;
    logic signed [32:0] r1_d21, r1_d02, r1_d10, r1_p01, r1_p12, r1_p02;
    logic               r1_g0011, r1_g0022, r1_g1122;
    logic signed [31:0] r1_r00, r1_r11, r1_r22;

    // Stage 2
    logic signed [34:0] n_rad, r2_rad;
    logic signed [34:0] n_v [4];
    logic signed [34:0] r2_v [4];

    // Stage 3
    logic [33:0] n_a [4];
    logic [33:0] r3_a [4];
    logic [3:0]  r3_neg;
    logic        r3_bad, r3_small;
    logic [12:0] r3_rad13;

    // Stage 4
    logic [33:0] r4_a [4];
    logic [3:0]  r4_neg;
    logic        r4_bad, r4_small;
    logic [12:0] r4_rad13;
    logic [25:0] r4_sq [4];
    logic [33:0] r4_m01, r4_m23;

    // Stage 5
    logic [33:0] r5_a [4];
    logic [3:0]  r5_neg;
    logic        r5_bad, r5_small;
    logic [12:0] r5_rad13;
    logic [33:0] r5_mx;
    logic [27:0] r5_s0;

    // Stage 6
    logic [33:0] r6_a [4];
    logic [3:0]  r6_neg;
    logic        r6_bad, r6_small;
    logic [12:0] r6_rad13;
    logic [5:0]  r6_p;
    logic [47:0] r6_prod;

    // Stage 7
    logic [63:0] n_sh [4];
    logic [30:0] r7_an [4];
    logic [3:0]  r7_neg;
    logic        r7_fb;

    // Stage 8
    logic [30:0] r8_an [4];
    logic [61:0] r8_sq [4];
    logic [3:0]  r8_neg;
    logic        r8_fb;

    // Stage 9
    logic [63:0] r9_sum;
    logic [30:0] r9_an [4];
    logic [3:0]  r9_neg;
    logic        r9_fb;

    always_comb begin
        n_rad = '0;
        n_v[0] = '0;
        n_v[1] = '0;
        n_v[2] = '0;
        n_v[3] = '0;
        if (r1_tr > 34'sd0) begin
            n_rad  = ONE35 + 35'(r1_tr);
            n_v[0] = n_rad;
            n_v[1] = 35'(r1_d21);
            n_v[2] = 35'(r1_d02);
            n_v[3] = 35'(r1_d10);
        end else if (r1_g0011 && r1_g0022) begin
            n_rad  = ONE35 + 35'(r1_r00) - 35'(r1_r11) - 35'(r1_r22);
            n_v[0] = 35'(r1_d21);
            n_v[1] = n_rad;
            n_v[2] = 35'(r1_p01);
            n_v[3] = 35'(r1_p02);
        end else if (r1_g1122) begin
            n_rad  = ONE35 + 35'(r1_r11) - 35'(r1_r00) - 35'(r1_r22);
            n_v[0] = 35'(r1_d02);
            n_v[1] = 35'(r1_p01);
            n_v[2] = n_rad;
            n_v[3] = 35'(r1_p12);
        end else begin
            n_rad  = ONE35 + 35'(r1_r22) - 35'(r1_r00) - 35'(r1_r11);
            n_v[0] = 35'(r1_d10);
            n_v[1] = 35'(r1_p02);
            n_v[2] = 35'(r1_p12);
            n_v[3] = n_rad;
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_a[i]  = r2_v[i][34] ? 34'(-r2_v[i]) : r2_v[i][33:0];
            // Normalize so the leading one lands at bit 30.
            n_sh[i] = {r6_a[i], 30'b0} >> r6_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[7:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_tr    <= 34'(i_r00) + 34'(i_r11) + 34'(i_r22);
        r1_d21   <= 33'(i_r21) - 33'(i_r12);
        r1_d02   <= 33'(i_r02) - 33'(i_r20);
        r1_d10   <= 33'(i_r10) - 33'(i_r01);
        r1_p01   <= 33'(i_r01) + 33'(i_r10);
        r1_p12   <= 33'(i_r12) + 33'(i_r21);
        r1_p02   <= 33'(i_r02) + 33'(i_r20);
        r1_g0011 <= i_r00 > i_r11;
        r1_g0022 <= i_r00 > i_r22;
        r1_g1122 <= i_r11 > i_r22;
        r1_r00   <= i_r00;
        r1_r11   <= i_r11;
        r1_r22   <= i_r22;

        r2_rad <= n_rad;
        r2_v   <= n_v;

        r3_a     <= n_a;
        r3_neg   <= {r2_v[3][34], r2_v[2][34], r2_v[1][34], r2_v[0][34]};
        r3_bad   <= r2_rad <= 35'sd0;
        r3_rad13 <= r2_rad[12:0];
        r3_small <= (n_a[0] < rmq_pkg::RMQ_SMALL_LIM) && (n_a[1] < rmq_pkg::RMQ_SMALL_LIM)
                 && (n_a[2] < rmq_pkg::RMQ_SMALL_LIM) && (n_a[3] < rmq_pkg::RMQ_SMALL_LIM);

        r4_a     <= r3_a;
        r4_neg   <= r3_neg;
        r4_bad   <= r3_bad;
        r4_small <= r3_small;
        r4_rad13 <= r3_rad13;
        for (int i = 0; i < 4; i++) begin
            r4_sq[i] <= r3_a[i][12:0] * r3_a[i][12:0];
        end
        r4_m01 <= (r3_a[0] > r3_a[1]) ? r3_a[0] : r3_a[1];
        r4_m23 <= (r3_a[2] > r3_a[3]) ? r3_a[2] : r3_a[3];

        r5_a     <= r4_a;
        r5_neg   <= r4_neg;
        r5_bad   <= r4_bad;
        r5_small <= r4_small;
        r5_rad13 <= r4_rad13;
        r5_mx    <= (r4_m01 > r4_m23) ? r4_m01 : r4_m23;
        r5_s0    <= 28'(r4_sq[0]) + 28'(r4_sq[1]) + 28'(r4_sq[2]) + 28'(r4_sq[3]);

        r6_a     <= r5_a;
        r6_neg   <= r5_neg;
        r6_bad   <= r5_bad;
        r6_small <= r5_small;
        r6_rad13 <= r5_rad13;
        r6_p     <= rmq_pkg::msb_pos(r5_mx);
        r6_prod  <= r5_s0 * rmq_pkg::RMQ_SHORT_K;

        for (int i = 0; i < 4; i++) begin
            r7_an[i] <= n_sh[i][30:0];
        end
        r7_neg <= r6_neg;
        // In the short case the radicand is itself below the small limit.
        r7_fb  <= r6_bad || (r6_small && (r6_prod < 48'({r6_rad13, 32'b0})));

        r8_an  <= r7_an;
        for (int i = 0; i < 4; i++) begin
            r8_sq[i] <= r7_an[i] * r7_an[i];
        end
        r8_neg <= r7_neg;
        r8_fb  <= r7_fb;

        r9_sum <= 64'(r8_sq[0]) + 64'(r8_sq[1]) + 64'(r8_sq[2]) + 64'(r8_sq[3]);
        r9_an  <= r8_an;
        r9_neg <= r8_neg;
        r9_fb  <= r8_fb;
    end

    assign o_valid = r_vld[8];
    assign o_sum   = r9_sum;
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            o_side.mag[i] = r9_an[i];
        end
        o_side.neg = r9_neg;
        o_side.fb  = r9_fb;
    end

endmodule

>>> rtl/core/rmq_sqrt.sv
// Pipelined integer square root of a 64-bit sum, one root bit per stage.
// Carries the side-band word alongside. Depends on rmq_pkg.
module rmq_sqrt (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [63:0]     i_sum,
    input  rmq_pkg::t_side  i_side,
    output logic            o_valid,
    output logic [31:0]     o_root,
    output rmq_pkg::t_side  o_side
);

    localparam int N = rmq_pkg::RMQ_SQRT_LAT;

    logic [N-1:0]   r_vld;
    logic [33:0]    r_rem  [N];
    logic [31:0]    r_root [N];
    logic [63:0]    r_s    [N];
    rmq_pkg::t_side r_side [N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[N-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stg
        logic [33:0]    rem_in;
        logic [31:0]    root_in;
        logic [63:0]    s_in;
        rmq_pkg::t_side side_in;
        logic [35:0]    rem2, trial;
        logic           ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign s_in    = i_sum;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign s_in    = r_s[k-1];
            assign side_in = r_side[k-1];
        end

        // Bring down the next bit pair and try 4*root+1 against it.
        assign rem2  = {rem_in, s_in[63:62]};
        assign trial = {2'b00, root_in, 2'b01};
        assign ge    = rem2 >= trial;

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= ge ? 34'(rem2 - trial) : rem2[33:0];
            r_root[k] <= {root_in[30:0], ge};
            r_s[k]    <= {s_in[61:0], 2'b00};
            r_side[k] <= side_in;
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_root  = r_root[N-1];
    assign o_side  = r_side[N-1];

endmodule

>>> rtl/core/rmq_div.sv
// Four-lane pipelined restoring divider: (mag * 2^30 + n/2) / n per lane,
// one quotient bit per stage after a rounding stage. Depends on rmq_pkg.
module rmq_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [31:0]       i_n,
    input  rmq_pkg::t_side    i_side,
    output logic              o_valid,
    output logic [3:0][30:0]  o_q,
    output logic [3:0]        o_neg,
    output logic              o_fb
);

    localparam int N = rmq_pkg::RMQ_DIV_LAT;

    logic [N-1:0]      r_vld;
    logic [31:0]       r_n   [N];
    logic [3:0][31:0]  r_rem [N];
    logic [3:0][30:0]  r_low [N];
    logic [3:0][30:0]  r_q   [N];
    logic [3:0]        r_neg [N];
    logic              r_fb  [N];
    logic [61:0]       n_d   [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[N-2:0], i_valid};
        end
    end

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            n_d[l] = {1'b0, i_side.mag[l], 30'b0} + 62'(i_n[31:1]);
        end
    end

    // The quotient stays below 2^31, so the top bits already sit below n.
    always_ff @(posedge i_clk) begin
        r_n[0]   <= i_n;
        r_neg[0] <= i_side.neg;
        r_fb[0]  <= i_side.fb;
        r_q[0]   <= '0;
        for (int l = 0; l < 4; l++) begin
            r_rem[0][l] <= 32'(n_d[l][61:31]);
            r_low[0][l] <= n_d[l][30:0];
        end
    end

    for (genvar k = 1; k < N; k++) begin : g_stg
        logic [3:0][32:0] rem2;
        logic [3:0]       ge;

        always_comb begin
            for (int l = 0; l < 4; l++) begin
                rem2[l] = {r_rem[k-1][l], r_low[k-1][l][30]};
                ge[l]   = rem2[l] >= {1'b0, r_n[k-1]};
            end
        end

        always_ff @(posedge i_clk) begin
            r_n[k]   <= r_n[k-1];
            r_neg[k] <= r_neg[k-1];
            r_fb[k]  <= r_fb[k-1];
            for (int l = 0; l < 4; l++) begin
                r_rem[k][l] <= ge[l] ? 32'(rem2[l] - {1'b0, r_n[k-1]}) : rem2[l][31:0];
                r_low[k][l] <= {r_low[k-1][l][29:0], 1'b0};
                r_q[k][l]   <= {r_q[k-1][l][29:0], ge[l]};
            end
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_q     = r_q[N-1];
    assign o_neg   = r_neg[N-1];
    assign o_fb    = r_fb[N-1];

endmodule

>>> rtl/core/rotation_matrix_to_quaternion_top.sv
// Top level of the rotation matrix to quaternion block.
// Instantiates rmq_front, rmq_sqrt and rmq_div; depends on rmq_pkg.
//
// Usage:
// A word is nine signed Q2.30 matrix entries on i_r00..i_r22. It is taken
// at a rising edge where start is high and busy is low. busy is high only
// during reset and the cycle after it, so a new word may be taken in every
// cycle. Each word yields one quaternion word on o_quat_w..o_quat_z with
// o_fell_back, shown for exactly one cycle while o_done is high, in the
// order the words came in. The receiver cannot hold results off, and none
// is needed: the pipeline never stalls.
// A word passes, from the accepting edge to the edge that takes the result,
// nine front stages (branch, magnitudes, short test, normalization,
// sum of squares), 32 square-root stages that settle one root bit each,
// a rounding stage plus 31 divider stages that settle one quotient bit each,
// and an output register. Throughput is one word per cycle.
// A synchronous reset on i_rst_n drops every word in flight; no result
// appears for a word that was not accepted after reset.
module rotation_matrix_to_quaternion_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_r00,
    input  logic signed [31:0] i_r01,
    input  logic signed [31:0] i_r02,
    input  logic signed [31:0] i_r10,
    input  logic signed [31:0] i_r11,
    input  logic signed [31:0] i_r12,
    input  logic signed [31:0] i_r20,
    input  logic signed [31:0] i_r21,
    input  logic signed [31:0] i_r22,
    output logic               o_done,
    output logic signed [31:0] o_quat_w,
    output logic signed [31:0] o_quat_x,
    output logic signed [31:0] o_quat_y,
    output logic signed [31:0] o_quat_z,
    output logic               o_fell_back
);

    logic            r_run;
    logic            w_acc;
    logic            f_valid;
    logic [63:0]     f_sum;
    rmq_pkg::t_side  f_side;
    logic            s_valid;
    logic [31:0]     s_root;
    rmq_pkg::t_side  s_side;
    logic            d_valid;
    logic [3:0][30:0] d_q;
    logic [3:0]      d_neg;
    logic            d_fb;
    logic [31:0]     n_out [4];
    logic [31:0]     mag;

    logic            r_done, r_fb;
    logic [31:0]     r_out [4];

    assign busy  = !r_run;
    assign w_acc = start && !busy;

    rmq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_acc),
        .i_r00   (i_r00),
        .i_r01   (i_r01),
        .i_r02   (i_r02),
        .i_r10   (i_r10),
        .i_r11   (i_r11),
        .i_r12   (i_r12),
        .i_r20   (i_r20),
        .i_r21   (i_r21),
        .i_r22   (i_r22),
        .o_valid (f_valid),
        .o_sum   (f_sum),
        .o_side  (f_side)
    );

    rmq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_sum   (f_sum),
        .i_side  (f_side),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    rmq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid),
        .i_n     (s_root),
        .i_side  (s_side),
        .o_valid (d_valid),
        .o_q     (d_q),
        .o_neg   (d_neg),
        .o_fb    (d_fb)
    );

    always_comb begin
        mag = '0;
        for (int l = 0; l < 4; l++) begin
            mag = {1'b0, d_q[l]};
            if (mag > rmq_pkg::RMQ_ONE_Q30) begin
                mag = rmq_pkg::RMQ_ONE_Q30;
            end
            n_out[l] = d_neg[l] ? 32'(-mag) : mag;
            if (d_fb) begin
                n_out[l] = (l == 0) ? rmq_pkg::RMQ_ONE_Q30 : 32'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= 1'b1;
            r_done <= d_valid;
        end
        r_out <= n_out;
        r_fb  <= d_fb;
    end

    assign o_done      = r_done;
    assign o_quat_w    = r_out[0];
    assign o_quat_x    = r_out[1];
    assign o_quat_y    = r_out[2];
    assign o_quat_z    = r_out[3];
    assign o_fell_back = r_fb;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##(rmq_pkg::RMQ_LAT) o_done)
        else $error("accepted word produced no result at the expected cycle");

    a_fallback_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_fell_back) |-> (o_quat_w == rmq_pkg::RMQ_ONE_Q30 && o_quat_x == 32'd0
            && o_quat_y == 32'd0 && o_quat_z == 32'd0))
        else $error("fallback result is not the identity quaternion");

    a_w_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_quat_w <= $signed(rmq_pkg::RMQ_ONE_Q30)
            && o_quat_w >= -$signed(rmq_pkg::RMQ_ONE_Q30)))
        else $error("scalar part exceeds unit magnitude");

endmodule
